FILE: rtl/core/at_response_line_detector_unit_assert.svh
// ---------------------------------------------------------------------------
// at_response_line_detector_unit_assert
// assertion macros used by the checker file of the line detector
// ---------------------------------------------------------------------------
`ifndef AT_RESPONSE_LINE_DETECTOR_UNIT_ASSERT_SVH
`define AT_RESPONSE_LINE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ARDET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ARDET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ardet_pkg.sv
// ---------------------------------------------------------------------------
// ardet_pkg
// types, codes and constants of the at response line detector
// ---------------------------------------------------------------------------
package ardet_pkg;

	// request codes on the input transaction
	localparam logic [2:0] REQ_BYTE      = 3'd0;
	localparam logic [2:0] REQ_TICK      = 3'd1;
	localparam logic [2:0] REQ_TAKE_LINE = 3'd2;
	localparam logic [2:0] REQ_TAKE_RESP = 3'd3;
	localparam logic [2:0] REQ_CLEAR     = 3'd4;

	// event codes on the result transaction
	localparam logic [1:0] EV_LINE_END  = 2'd0;
	localparam logic [1:0] EV_TIMEOUT   = 2'd1;
	localparam logic [1:0] EV_LINE_TAKE = 2'd2;
	localparam logic [1:0] EV_RESP_TAKE = 2'd3;

	// internal command codes after classification
	localparam logic [2:0] CMD_CHAR      = 3'd0;
	localparam logic [2:0] CMD_CR        = 3'd1;
	localparam logic [2:0] CMD_LF        = 3'd2;
	localparam logic [2:0] CMD_TICK      = 3'd3;
	localparam logic [2:0] CMD_TAKE_LINE = 3'd4;
	localparam logic [2:0] CMD_TAKE_RESP = 3'd5;
	localparam logic [2:0] CMD_CLEAR     = 3'd6;

	// ok matcher states
	localparam logic [1:0] OKP_EMPTY = 2'd0;
	localparam logic [1:0] OKP_O     = 2'd1;
	localparam logic [1:0] OKP_OK    = 2'd2;
	localparam logic [1:0] OKP_OTHER = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLED  = 2'd0;
	localparam logic [1:0] CFG_IDLE_LIM = 2'd1;
	localparam logic [1:0] CFG_MAX_LINE = 2'd2;

	localparam logic        RST_ENABLED  = 1'b1;
	localparam logic [15:0] RST_IDLE_LIM = 16'd100;
	localparam logic [9:0]  RST_MAX_LINE = 10'd256;

	localparam int CFG_DW = 16;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_O  = 8'h4F;
	localparam logic [7:0] CHAR_K  = 8'h4B;
	localparam logic [7:0] CHAR_E  = 8'h45;
	localparam logic [7:0] CHAR_R  = 8'h52;

	// length of the word ERROR
	localparam logic [2:0] ERR_LEN = 3'd5;

	localparam logic [15:0] IDLE_MAX  = 16'hFFFF;
	localparam logic [7:0]  LINES_MAX = 8'hFF;

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// result queue at the output
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] rx_byte;
	} ardet_req_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [9:0] line_length;
		logic       line_is_ok;
		logic       line_has_error;
		logic       response_complete;
		logic [7:0] lines_in_response;
		logic       had_data;
	} ardet_res_t;

	typedef struct packed {
		logic        enabled;
		logic [15:0] idle_limit_ms;
		logic [9:0]  max_line;
	} ardet_cfg_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0] op;
		logic       is_o;
		logic       is_k;
		logic       is_e;
		logic       is_r;
	} ardet_cmd_t;

endpackage

FILE: rtl/core/at_response_line_detector_unit.sv
// ---------------------------------------------------------------------------
// at_response_line_detector_unit
// splits a modem receive stream into lines and tracks response completion
//
// input side is a queue: drive req and raise push while full is low; each
// transaction carries a receive byte, a millisecond tick, a take-line, a
// take-response or a clear request. output side is a queue too: while
// empty is low the oldest result sits on res, and pop takes it.
// one input transaction can be taken every cycle while full is low. a result
// passes through the command queue, then the line state machine writes it
// straight into a two-entry result queue, from which it shows on res.
// bytes other than line feed, ticks without timeout, clears and disabled or
// unknown requests give no result. when pop stays low, the result queue
// fills, the back end stops, the four-entry command queue fills and full
// rises; nothing is dropped. reset empties both queues, zeroes the line
// state and loads the register defaults (enabled, 100 ms idle limit, 256
// character lines). the user writes registers through cfg_we, cfg_idx and
// cfg_data only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module at_response_line_detector_unit import ardet_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// request queue
	input  logic              push,
	input  ardet_req_t        req,
	output logic              full,
	// result queue
	output logic              empty,
	input  logic              pop,
	output ardet_res_t        res,
	// register writes
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [CFG_DW-1:0] cfg_data
);

	ardet_cfg_t cfg_q;
	logic       cq_pop;
	logic       cq_empty;
	ardet_cmd_t cq_head;

	// register file, an index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= RST_ENABLED;
			cfg_q.idle_limit_ms <= RST_IDLE_LIM;
			cfg_q.max_line      <= RST_MAX_LINE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ENABLED:  cfg_q.enabled       <= cfg_data[0];
				CFG_IDLE_LIM: cfg_q.idle_limit_ms <= cfg_data[15:0];
				CFG_MAX_LINE: cfg_q.max_line      <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// front: classify each request and queue it
	ardet_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enabled  (cfg_q.enabled),
		.push     (push),
		.req      (req),
		.full     (full),
		.cq_pop   (cq_pop),
		.cq_empty (cq_empty),
		.cq_head  (cq_head)
	);

	// back: run the line state machine and queue results
	ardet_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cq_empty (cq_empty),
		.cmd      (cq_head),
		.cq_pop   (cq_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

endmodule

FILE: rtl/core/ardet_front.sv
// ---------------------------------------------------------------------------
// ardet_front
// classifies input transactions and queues them for the back end
// ---------------------------------------------------------------------------
module ardet_front import ardet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       enabled,
	input  logic       push,
	input  ardet_req_t req,
	output logic       full,
	input  logic       cq_pop,
	output logic       cq_empty,
	output ardet_cmd_t cq_head
);

	ardet_cmd_t cmd_cls;
	logic       keep;
	logic       wr_en;
	logic       rd_en;

	ardet_cmd_t           cq_q [CQ_DEPTH];
	logic [CQ_AW-1:0]     wr_ptr_q;
	logic [CQ_AW-1:0]     rd_ptr_q;
	logic [CQ_CW-1:0]     cnt_q;

	always_comb begin
		cmd_cls.op   = CMD_CHAR;
		cmd_cls.is_o = (req.rx_byte == CHAR_O);
		cmd_cls.is_k = (req.rx_byte == CHAR_K);
		cmd_cls.is_e = (req.rx_byte == CHAR_E);
		cmd_cls.is_r = (req.rx_byte == CHAR_R);
		keep         = enabled;
		unique case (req.req_type)
			REQ_BYTE: begin
				if (req.rx_byte == CHAR_LF) begin
					cmd_cls.op = CMD_LF;
				end else if (req.rx_byte == CHAR_CR) begin
					cmd_cls.op = CMD_CR;
				end else begin
					cmd_cls.op = CMD_CHAR;
				end
			end
			REQ_TICK:      cmd_cls.op = CMD_TICK;
			REQ_TAKE_LINE: cmd_cls.op = CMD_TAKE_LINE;
			REQ_TAKE_RESP: cmd_cls.op = CMD_TAKE_RESP;
			REQ_CLEAR:     cmd_cls.op = CMD_CLEAR;
			default:       keep = 1'b0;
		endcase
	end

	assign full     = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign cq_empty = (cnt_q == '0);
	assign cq_head  = cq_q[rd_ptr_q];

	// disabled or unknown requests are taken and dropped here
	assign wr_en = push && !full && keep;
	assign rd_en = cq_pop && !cq_empty;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cq_q[wr_ptr_q] <= cmd_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + CQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CQ_AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CQ_CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CQ_CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/ardet_back.sv
// ---------------------------------------------------------------------------
// ardet_back
// line and response state machine with the result queue
// ---------------------------------------------------------------------------
module ardet_back import ardet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ardet_cfg_t cfg,
	input  logic       cq_empty,
	input  ardet_cmd_t cmd,
	output logic       cq_pop,
	input  logic       pop,
	output logic       empty,
	output ardet_res_t res
);

	logic [9:0]  cur_len_q, cur_len_d;
	logic [1:0]  ok_pre_q, ok_pre_d;
	logic [2:0]  err_pre_q, err_pre_d;
	logic        err_seen_q, err_seen_d;
	logic [9:0]  last_len_q, last_len_d;
	logic        last_ok_q, last_ok_d;
	logic        last_err_q, last_err_d;
	logic        new_line_q, new_line_d;
	logic        complete_q, complete_d;
	logic [15:0] idle_q, idle_d;
	logic [7:0]  lines_q, lines_d;

	logic        exec;
	logic        err_match;
	logic [2:0]  err_step;
	logic        emit_vld;
	logic [1:0]  emit_ev;
	logic        emit_had;
	ardet_res_t  res_d;

	ardet_res_t       oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wr_q;
	logic [OQ_AW-1:0] oq_rd_q;
	logic [OQ_CW-1:0] oq_cnt_q;
	logic             oq_wr;
	logic             oq_rd;

	// a slot frees up when the head result leaves in the same cycle
	assign exec   = !cq_empty && ((oq_cnt_q != OQ_CW'(OQ_DEPTH)) || pop);
	assign cq_pop = exec;

	// next character of ERROR expected at this match position
	always_comb begin
		err_match = 1'b0;
		case (err_pre_q)
			3'd0:             err_match = cmd.is_e;
			3'd1, 3'd2, 3'd4: err_match = cmd.is_r;
			3'd3:             err_match = cmd.is_o;
			default:          err_match = 1'b0;
		endcase
		if (err_match) begin
			err_step = err_pre_q + 3'd1;
		end else begin
			err_step = cmd.is_e ? 3'd1 : 3'd0;
		end
	end

	always_comb begin
		cur_len_d  = cur_len_q;
		ok_pre_d   = ok_pre_q;
		err_pre_d  = err_pre_q;
		err_seen_d = err_seen_q;
		last_len_d = last_len_q;
		last_ok_d  = last_ok_q;
		last_err_d = last_err_q;
		new_line_d = new_line_q;
		complete_d = complete_q;
		idle_d     = idle_q;
		lines_d    = lines_q;
		emit_vld   = 1'b0;
		emit_ev    = EV_LINE_END;
		emit_had   = 1'b0;
		unique case (cmd.op)
			CMD_CHAR: begin
				idle_d = '0;
				if (cur_len_q >= cfg.max_line) begin
					// overlong line, drop it along with this character
					cur_len_d  = '0;
					ok_pre_d   = OKP_EMPTY;
					err_pre_d  = '0;
					err_seen_d = 1'b0;
				end else begin
					cur_len_d = cur_len_q + 10'd1;
					if (ok_pre_q == OKP_EMPTY && cmd.is_o) begin
						ok_pre_d = OKP_O;
					end else if (ok_pre_q == OKP_O && cmd.is_k) begin
						ok_pre_d = OKP_OK;
					end else begin
						ok_pre_d = OKP_OTHER;
					end
					if (err_step == ERR_LEN) begin
						err_seen_d = 1'b1;
						err_pre_d  = '0;
					end else begin
						err_pre_d = err_step;
					end
				end
			end
			CMD_CR: begin
				idle_d = '0;
			end
			CMD_LF: begin
				idle_d     = '0;
				last_len_d = cur_len_q;
				last_ok_d  = (ok_pre_q == OKP_OK);
				last_err_d = err_seen_q;
				cur_len_d  = '0;
				ok_pre_d   = OKP_EMPTY;
				err_pre_d  = '0;
				err_seen_d = 1'b0;
				if (cur_len_q != '0 && lines_q != LINES_MAX) begin
					lines_d = lines_q + 8'd1;
				end
				new_line_d = 1'b1;
				if ((ok_pre_q == OKP_OK) || err_seen_q) begin
					complete_d = 1'b1;
				end
				emit_vld = 1'b1;
				emit_ev  = EV_LINE_END;
			end
			CMD_TICK: begin
				if (idle_q != IDLE_MAX) begin
					idle_d = idle_q + 16'd1;
				end
				if (new_line_q && !complete_q && (idle_d > cfg.idle_limit_ms)) begin
					complete_d = 1'b1;
					emit_vld   = 1'b1;
					emit_ev    = EV_TIMEOUT;
				end
			end
			CMD_TAKE_LINE: begin
				new_line_d = 1'b0;
				emit_vld   = 1'b1;
				emit_ev    = EV_LINE_TAKE;
				emit_had   = new_line_q;
			end
			CMD_TAKE_RESP: begin
				complete_d = 1'b0;
				lines_d    = '0;
				emit_vld   = 1'b1;
				emit_ev    = EV_RESP_TAKE;
				emit_had   = complete_q;
			end
			CMD_CLEAR: begin
				cur_len_d  = '0;
				ok_pre_d   = OKP_EMPTY;
				err_pre_d  = '0;
				err_seen_d = 1'b0;
				last_len_d = '0;
				last_ok_d  = 1'b0;
				last_err_d = 1'b0;
				new_line_d = 1'b0;
				complete_d = 1'b0;
				idle_d     = '0;
				lines_d    = '0;
			end
			default: begin
			end
		endcase

		res_d.event_res         = emit_ev;
		res_d.line_length       = last_len_d;
		res_d.line_is_ok        = last_ok_d;
		res_d.line_has_error    = last_err_d;
		res_d.response_complete = complete_d;
		res_d.lines_in_response = lines_d;
		res_d.had_data          = emit_had;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q  <= '0;
			ok_pre_q   <= OKP_EMPTY;
			err_pre_q  <= '0;
			err_seen_q <= 1'b0;
			last_len_q <= '0;
			last_ok_q  <= 1'b0;
			last_err_q <= 1'b0;
			new_line_q <= 1'b0;
			complete_q <= 1'b0;
			idle_q     <= '0;
			lines_q    <= '0;
		end else if (exec) begin
			cur_len_q  <= cur_len_d;
			ok_pre_q   <= ok_pre_d;
			err_pre_q  <= err_pre_d;
			err_seen_q <= err_seen_d;
			last_len_q <= last_len_d;
			last_ok_q  <= last_ok_d;
			last_err_q <= last_err_d;
			new_line_q <= new_line_d;
			complete_q <= complete_d;
			idle_q     <= idle_d;
			lines_q    <= lines_d;
		end
	end

	assign oq_wr = exec && emit_vld;
	assign oq_rd = pop && !empty;
	assign empty = (oq_cnt_q == '0);
	assign res   = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_q[oq_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_wr) begin
				oq_wr_q <= oq_wr_q + OQ_AW'(1);
			end
			if (oq_rd) begin
				oq_rd_q <= oq_rd_q + OQ_AW'(1);
			end
			if (oq_wr && !oq_rd) begin
				oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
			end else if (oq_rd && !oq_wr) begin
				oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/ardet_checker.sv
// ---------------------------------------------------------------------------
// ardet_checker
// port level checks of the at response line detector, bound to the top
// ---------------------------------------------------------------------------
`include "at_response_line_detector_unit_assert.svh"

module ardet_checker import ardet_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input ardet_res_t res
);

	// a waiting result holds until it is popped
	`ARDET_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(res), "result changed before pop")

	// line end and timeout transactions never carry had_data
	`ARDET_ASSERT_NOW(a_no_had, !empty && (res.event_res == EV_LINE_END || res.event_res == EV_TIMEOUT), !res.had_data, "had_data set on a non-take event")

	// a timeout always reports the response as complete
	`ARDET_ASSERT_NOW(a_timeout_done, !empty && res.event_res == EV_TIMEOUT, res.response_complete, "timeout without completion")

	// taking the response leaves flag and line count cleared
	`ARDET_ASSERT_NOW(a_take_clr, !empty && res.event_res == EV_RESP_TAKE, !res.response_complete && res.lines_in_response == 8'd0, "response take did not clear")

	// a line that is exactly OK cannot contain ERROR
	`ARDET_ASSERT_NOW(a_ok_err, !empty, !(res.line_is_ok && res.line_has_error), "line both ok and error")

endmodule

bind at_response_line_detector_unit ardet_checker u_ardet_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.res    (res)
);

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// checks the at response line detector against a cycle-free line tracker
//
// requests go in through the push/full queue and results come back through
// the empty/pop queue, both sides with random gaps. every accepted request
// updates a local copy of the line state, and any report it causes is queued.
// each popped result is compared field by field with the oldest queued one.
// registers are only written once the block has gone quiet.
// ---------------------------------------------------------------------------
module tb;
	import ardet_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 9;
	// command queue plus pipeline, with margin
	localparam int SETTLE_CYCLES = 10;
	localparam int QUIET_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 10;
	// line limit used for the directed overlong line check
	localparam int LONG_LINE     = 40;

	// request codes the block ignores
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;
	// register index with no register behind it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// characters of the error word, first one in the top byte
	localparam logic [39:0] ERR_WORD = {CHAR_E, CHAR_R, CHAR_R, CHAR_O, CHAR_R};

	logic              clk;
	logic              arst_n;
	logic              push;
	ardet_req_t        req;
	logic              full;
	logic              empty;
	logic              pop;
	ardet_res_t        res;
	logic              cfg_we;
	logic [1:0]        cfg_idx;
	logic [CFG_DW-1:0] cfg_data;

	at_response_line_detector_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.req      (req),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// register copies
	logic        cfg_enabled;
	logic [15:0] cfg_idle_limit;
	logic [9:0]  cfg_max_line;

	// line tracker state
	logic [9:0]  cur_len;
	logic [1:0]  ok_state;
	logic [2:0]  err_pos;
	logic        err_seen;
	logic [9:0]  last_len;
	logic        last_ok;
	logic        last_err;
	logic        line_ready;
	logic        resp_done;
	logic [15:0] idle_ticks;
	logic [7:0]  line_total;

	// reports still owed by the block, oldest first
	ardet_res_t line_reports_due[$];

	int  fail_count;
	int  items_sent;
	int  quiet_cycles;
	bit  src_busy;
	bit  sink_busy;
	int  sink_hold;

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// line tracker
	// ------------------------------------------------------------------

	// drop the line being built
	task automatic forget_line();
		cur_len  = '0;
		ok_state = OKP_EMPTY;
		err_pos  = '0;
		err_seen = 1'b0;
	endtask

	// everything back to zero, registers untouched
	task automatic forget_all();
		forget_line();
		last_len   = '0;
		last_ok    = 1'b0;
		last_err   = 1'b0;
		line_ready = 1'b0;
		resp_done  = 1'b0;
		idle_ticks = '0;
		line_total = '0;
	endtask

	task automatic queue_report(input logic [1:0] ev, input logic had);
		ardet_res_t r;
		r.event_res         = ev;
		r.line_length       = last_len;
		r.line_is_ok        = last_ok;
		r.line_has_error    = last_err;
		r.response_complete = resp_done;
		r.lines_in_response = line_total;
		r.had_data          = had;
		line_reports_due.push_back(r);
	endtask

	// ordinary character: grow the line or throw it away when too long
	task automatic grow_line(input logic [7:0] ch);
		if (cur_len >= cfg_max_line) begin
			forget_line();
			return;
		end
		cur_len = cur_len + 10'd1;
		if (ok_state == OKP_EMPTY && ch == CHAR_O)
			ok_state = OKP_O;
		else if (ok_state == OKP_O && ch == CHAR_K)
			ok_state = OKP_OK;
		else
			ok_state = OKP_OTHER;
		// simple restart matcher: a miss goes back to zero or to one on E
		if (err_pos < ERR_LEN && ch == ERR_WORD[39 - 8 * err_pos -: 8])
			err_pos = err_pos + 3'd1;
		else
			err_pos = (ch == CHAR_E) ? 3'd1 : 3'd0;
		if (err_pos >= ERR_LEN) begin
			err_seen = 1'b1;
			err_pos  = '0;
		end
	endtask

	// one accepted request transaction
	task automatic predict_report(input logic [2:0] kind, input logic [7:0] ch);
		logic had;
		if (!cfg_enabled)
			return;
		case (kind)
			REQ_BYTE: begin
				idle_ticks = '0;
				if (ch == CHAR_LF) begin
					last_len = cur_len;
					last_ok  = (ok_state == OKP_OK);
					last_err = err_seen;
					forget_line();
					if (last_len != 0 && line_total < LINES_MAX)
						line_total = line_total + 8'd1;
					line_ready = 1'b1;
					if (last_ok || last_err)
						resp_done = 1'b1;
					queue_report(EV_LINE_END, 1'b0);
				end else if (ch != CHAR_CR) begin
					grow_line(ch);
				end
			end
			REQ_TICK: begin
				if (idle_ticks < IDLE_MAX)
					idle_ticks = idle_ticks + 16'd1;
				if (line_ready && !resp_done && idle_ticks > cfg_idle_limit) begin
					resp_done = 1'b1;
					queue_report(EV_TIMEOUT, 1'b0);
				end
			end
			REQ_TAKE_LINE: begin
				had        = line_ready;
				line_ready = 1'b0;
				queue_report(EV_LINE_TAKE, had);
			end
			REQ_TAKE_RESP: begin
				had        = resp_done;
				resp_done  = 1'b0;
				line_total = '0;
				queue_report(EV_RESP_TAKE, had);
			end
			REQ_CLEAR: begin
				forget_all();
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// drivers; every task starts and ends on a falling edge
	// ------------------------------------------------------------------

	// mostly back to back, some short pauses, a few long ones
	function automatic int pick_gap(input bit busy);
		int r;
		if (!busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// one request transaction, tracked at the edge that takes it
	task automatic send_item(input logic [2:0] kind, input logic [7:0] ch);
		int gap;
		gap = pick_gap(src_busy);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push         = 1'b1;
		req.req_type = kind;
		req.rx_byte  = ch;
		do @(posedge clk); while (full);
		predict_report(kind, ch);
		if (cfg_enabled && kind <= REQ_CLEAR)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(REQ_BYTE, s[i]);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
	endtask

	// printable characters, no line control among them
	task automatic send_filler(input int n);
		repeat (n) send_item(REQ_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
	endtask

	// stop sending, wait for every owed report, then let the pipeline empty
	task automatic settle();
		push = 1'b0;
		while (line_reports_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only called after settle
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ENABLED:  cfg_enabled    = data[0];
			CFG_IDLE_LIM: cfg_idle_limit = data[15:0];
			CFG_MAX_LINE: cfg_max_line   = data[9:0];
			default: ;
		endcase
	endtask

	// result side: pop held high for stretches, broken by random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			pop       = 1'b0;
			sink_hold = 0;
		end else if (sink_hold != 0) begin
			pop = 1'b0;
			sink_hold--;
		end else begin
			pop       = 1'b1;
			sink_hold = pick_gap(sink_busy);
		end
	end

	// ------------------------------------------------------------------
	// result check
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		ardet_res_t want;
		if (arst_n && pop && !empty) begin
			if (line_reports_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: result transaction with none expected: ev %0d len %0d",
						$time, res.event_res, res.line_length);
			end else begin
				want = line_reports_due.pop_front();
				if (res.event_res !== want.event_res ||
					res.line_length !== want.line_length ||
					res.line_is_ok !== want.line_is_ok ||
					res.line_has_error !== want.line_has_error ||
					res.response_complete !== want.response_complete ||
					res.lines_in_response !== want.lines_in_response ||
					res.had_data !== want.had_data) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("%0t: expected ev %0d len %0d ok %0b err %0b %s",
							$time, want.event_res, want.line_length, want.line_is_ok,
							want.line_has_error, "");
						$display("    done %0b lines %0d had %0b",
							want.response_complete, want.lines_in_response,
							want.had_data);
						$display("%0t: actual   ev %0d len %0d ok %0b err %0b %s",
							$time, res.event_res, res.line_length, res.line_is_ok,
							res.line_has_error, "");
						$display("    done %0b lines %0d had %0b",
							res.response_complete, res.lines_in_response,
							res.had_data);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any transaction means a hang
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// ok line, error line, empty line, all request codes, byte extremes
	task automatic test_basic_lines();
		src_busy  = 1'b1;
		sink_busy = 1'b1;
		send_text("OK\r\n");
		send_item(REQ_BYTE, 8'h00);
		send_item(REQ_BYTE, 8'hFF);
		send_text("ERROR\n");
		send_item(REQ_TAKE_LINE, 8'h00);
		send_item(REQ_TAKE_RESP, 8'hFF);
		// nothing pending anymore
		send_item(REQ_TAKE_LINE, 8'h00);
		// empty line is reported but not counted
		send_text("\n");
		for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
			send_item(k[2:0], 8'hFF);
		send_item(REQ_TICK, 8'hFF);
		send_item(REQ_CLEAR, 8'hFF);
		send_item(REQ_TAKE_RESP, 8'h00);
		settle();
	endtask

	// disabled block ignores everything; upper data bits are masked off
	task automatic test_disabled();
		write_reg(CFG_ENABLED, 16'hFFFE);
		send_text("OK\n");
		send_item(REQ_TAKE_LINE, 8'h00);
		send_item(REQ_TAKE_RESP, 8'h00);
		send_ticks(3);
		settle();
		// index with no register behind it must change nothing
		write_reg(CFG_SPARE, 16'hFFFF);
		write_reg(CFG_ENABLED, 16'h0003);
		send_item(REQ_TAKE_LINE, 8'h00);
		send_text("AT\n");
		settle();
	endtask

	// timeout only after a line, only once, and any byte restarts the count
	task automatic test_idle_timeout();
		write_reg(CFG_IDLE_LIM, 16'h0001);
		send_item(REQ_TAKE_RESP, 8'h00);
		send_text("AT\n");
		send_ticks(4);
		send_item(REQ_TAKE_RESP, 8'h00);
		send_text("X\n");
		send_item(REQ_TICK, 8'h00);
		send_text("Y");
		send_ticks(3);
		send_item(REQ_TAKE_LINE, 8'h00);
		send_item(REQ_TAKE_RESP, 8'h00);
		// no line since the take: ticks alone do nothing
		send_ticks(4);
		settle();
	endtask

	// the largest limit holds the timeout off, a smaller one fires it at once
	task automatic test_idle_large_limit();
		src_busy = 1'b0;
		write_reg(CFG_IDLE_LIM, IDLE_MAX);
		send_item(REQ_TAKE_RESP, 8'h00);
		send_text("AT\n");
		send_ticks(6);
		settle();
		write_reg(CFG_IDLE_LIM, 16'd4);
		send_ticks(2);
		send_item(REQ_TAKE_RESP, 8'h00);
		settle();
		src_busy = 1'b1;
	endtask

	// lines longer than the limit are thrown away, character included
	task automatic test_overlong_line();
		write_reg(CFG_MAX_LINE, 16'hFC01);
		send_text("OK\n");
		send_text("Z\r\n");
		send_text("ERROR\n");
		settle();
		// zero length limit drops every character
		write_reg(CFG_MAX_LINE, 16'h0000);
		send_text("OK\r\n");
		settle();
		write_reg(CFG_MAX_LINE, 16'(LONG_LINE));
		send_filler(LONG_LINE);
		send_text("\n");
		send_filler(LONG_LINE + 1);
		send_text("OK\n");
		send_item(REQ_TAKE_RESP, 8'h00);
		settle();
		write_reg(CFG_MAX_LINE, {6'b0, RST_MAX_LINE});
	endtask

	// line count stops at its top until the response is taken
	task automatic test_line_count_saturation();
		send_item(REQ_TAKE_RESP, 8'h00);
		repeat (int'(LINES_MAX) + 5)
			send_text("A\n");
		send_item(REQ_TAKE_RESP, 8'h00);
		send_item(REQ_TAKE_RESP, 8'h00);
		settle();
	endtask

	// character for a random line, biased toward the matcher letters
	function automatic logic [7:0] line_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1:    c = CHAR_O;
			2:       c = CHAR_K;
			3, 4:    c = CHAR_E;
			5, 6:    c = CHAR_R;
			7:       c = CHAR_CR;
			8:       c = 8'($urandom_range(0, 255));
			default: c = 8'($urandom_range(8'h20, 8'h7E));
		endcase
		return (c == CHAR_LF) ? CHAR_R : c;
	endfunction

	// a terminated line: plain ok, error in the middle, or random text
	task automatic send_line(input int body_len);
		int head;
		case ($urandom_range(0, 3))
			0: send_text("OK");
			1: begin
				head = $urandom_range(0, body_len);
				repeat (head) send_item(REQ_BYTE, line_char());
				send_text("ERROR");
				repeat (body_len - head) send_item(REQ_BYTE, line_char());
			end
			default: repeat (body_len) send_item(REQ_BYTE, line_char());
		endcase
		if ($urandom_range(0, 1))
			send_item(REQ_BYTE, CHAR_CR);
		send_item(REQ_BYTE, CHAR_LF);
	endtask

	task automatic test_random_traffic(input int n_items, input logic [15:0] idle_lim,
		input logic [9:0] max_len, input bit src_on, input bit sink_on);
		int goal;
		int r;
		int len;
		settle();
		write_reg(CFG_IDLE_LIM, idle_lim);
		write_reg(CFG_MAX_LINE, {6'b0, max_len});
		src_busy  = src_on;
		sink_busy = sink_on;
		goal      = items_sent + n_items;
		while (items_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// mostly short lines, now and then one around a short limit
				if ($urandom_range(0, 9) == 0 && max_len <= 64)
					len = $urandom_range((max_len > 2) ? max_len - 2 : 0, max_len + 2);
				else
					len = $urandom_range(0, 8);
				send_line(len);
			end else if (r < 70) begin
				if ($urandom_range(0, 5) == 0 && idle_lim < 300)
					send_ticks(idle_lim + 2);
				else
					send_ticks($urandom_range(1, 6));
			end else if (r < 78) begin
				send_item(REQ_TAKE_LINE, 8'($urandom_range(0, 255)));
			end else if (r < 86) begin
				send_item(REQ_TAKE_RESP, 8'($urandom_range(0, 255)));
			end else if (r < 88) begin
				send_item(REQ_CLEAR, 8'($urandom_range(0, 255)));
			end else if (r < 91) begin
				send_item(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
					8'($urandom_range(0, 255)));
			end else if (r < 98) begin
				// stray characters, line ends included
				send_item(REQ_BYTE, 8'($urandom_range(0, 255)));
			end else if (r < 99) begin
				// hold back until the block has answered everything
				settle();
			end else begin
				src_busy  = ~src_busy;
				sink_busy = ~sink_busy;
			end
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		req          = '0;
		cfg_we       = 1'b0;
		cfg_idx      = CFG_ENABLED;
		cfg_data     = '0;
		fail_count   = 0;
		items_sent   = 0;
		quiet_cycles = 0;
		src_busy     = 1'b0;
		sink_busy    = 1'b0;
		cfg_enabled    = RST_ENABLED;
		cfg_idle_limit = RST_IDLE_LIM;
		cfg_max_line   = RST_MAX_LINE;
		forget_all();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_lines();
		test_disabled();
		test_idle_timeout();
		test_overlong_line();
		test_line_count_saturation();
		test_idle_large_limit();
		test_random_traffic(220, 16'd1, 10'd5, 1'b1, 1'b1);
		test_random_traffic(220, RST_IDLE_LIM, RST_MAX_LINE, 1'b0, 1'b0);
		test_random_traffic(220, 16'd3, 10'd1023, 1'b1, 1'b0);
		test_random_traffic(220, IDLE_MAX, 10'd12, 1'b0, 1'b1);
		test_random_traffic(220, 16'd7, 10'd1, 1'b1, 1'b1);

		settle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
